### hdl/pwi_pkg.sv
// shared types and constants for the windowed-integral pid controller
`default_nettype none

package pwi_pkg;

    localparam int HISTORY_DEPTH = 16;
    localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

    localparam int ERR_W   = 16;
    localparam int TIME_W  = 20;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 3;

    localparam int DIV_STEPS = 32;
    localparam int CNT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_UPPER = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_LOWER = 3'd4;

    typedef enum logic [2:0] {
        MS_P,
        MS_I0,
        MS_I1,
        MS_I2,
        MS_D0,
        MS_D1,
        MS_D2
    } mul_sel_t;

    localparam logic [2:0] MUL_LAST = 3'(MS_D2);

    typedef struct packed {
        logic     load;
        logic     prep;
        logic     div_step;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     acc_en;
        logic     finish;
    } dp_cmd_t;

    typedef struct packed {
        logic time_zero;
    } dp_sts_t;

endpackage

`default_nettype wire

### hdl/pwi_ctrl.sv
// sequencing state machine for the windowed-integral pid controller
`default_nettype none

module pwi_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire pwi_pkg::dp_sts_t sts,
    output pwi_pkg::dp_cmd_t      cmd
);
    import pwi_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_DRAIN,
        S_FINISH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd          = '0;
        cmd.mul_sel  = mul_sel_t'(cnt_reg[2:0]);
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (sts.time_zero)
                begin
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
                else
                begin
                    cmd.div_step = 1'b1;
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_next   = '0;
                        state_next = S_MUL;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.acc_en = (cnt_reg != '0);
                if (cnt_reg[2:0] == MUL_LAST)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                cmd.acc_en = 1'b1;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### hdl/pwi_datapath.sv
// arithmetic, window storage and configuration registers of the pid controller
`default_nettype none

module pwi_datapath (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire pwi_pkg::dp_cmd_t               cmd,
    output pwi_pkg::dp_sts_t                    sts,
    input  wire logic [pwi_pkg::ERR_W-1:0]      error_sample,
    input  wire logic [pwi_pkg::TIME_W-1:0]     elapsed_us,
    input  wire logic                           cfg_we,
    input  wire logic [pwi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwi_pkg::CFG_W-1:0]      cfg_data,
    output logic [31:0]                         drive,
    output logic                                clamped
);
    import pwi_pkg::*;

    // configuration
    logic [31:0] gain_p_reg, gain_i_reg, gain_d_reg, upper_reg, lower_reg;

    // per-item working registers
    logic [ERR_W-1:0]  e_reg;
    logic [TIME_W-1:0] t_reg;
    logic [36:0]       prod_reg;
    logic              neg_reg;
    logic [31:0]       div_reg;
    logic [19:0]       rem_reg;
    logic [44:0]       integ_reg;
    logic [32:0]       deriv_reg;
    logic [48:0]       mprod_reg;
    logic [1:0]        sh_reg;
    logic [79:0]       acc_reg;
    logic [31:0]       drive_reg;
    logic              clamped_reg;

    // controller state
    logic [ERR_W-1:0]      last_reg;
    logic [39:0]           win_reg [HISTORY_DEPTH];
    logic [HIST_IDX_W-1:0] ptr_reg, ptr_next;
    logic [43:0]           wsum_reg, wsum_next;

    logic signed [15:0] e_s;
    logic signed [20:0] t_s;
    logic signed [36:0] prod_c;
    logic [16:0]        diff;
    logic [16:0]        diff_mag;
    logic [20:0]        rem_sh;
    logic               geq;
    logic [20:0]        rem_sub;
    logic [32:0]        deriv_c;
    logic [47:0]        integ48, deriv48;
    logic signed [31:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [48:0] mul_p;
    logic [1:0]         sh_c;
    logic [79:0]        addend;
    logic signed [63:0] res_s, up_s, lo_s;
    logic [39:0]        oldest;

    function automatic logic [16:0] chunk_of(input logic [47:0] v, input logic [1:0] idx);
        logic [16:0] r;
        case (idx)
            2'd0:    r = {1'b0, v[15:0]};
            2'd1:    r = {1'b0, v[31:16]};
            default: r = {v[47], v[47:32]};
        endcase
        return r;
    endfunction

    assign sts.time_zero = (t_reg == '0);

    assign e_s    = e_reg;
    assign t_s    = {1'b0, t_reg};
    assign prod_c = e_s * t_s;

    assign diff     = {e_reg[15], e_reg} - {last_reg[15], last_reg};
    assign diff_mag = diff[16] ? (17'd0 - diff) : diff;

    // restoring divide, one quotient bit per step
    assign rem_sh  = {rem_reg, div_reg[31]};
    assign geq     = (rem_sh >= {1'b0, t_reg});
    assign rem_sub = rem_sh - {1'b0, t_reg};

    assign deriv_c = sts.time_zero ? 33'd0 :
                     (neg_reg ? (33'd0 - {1'b0, div_reg}) : {1'b0, div_reg});

    assign integ48 = {{3{integ_reg[44]}}, integ_reg};
    assign deriv48 = {{15{deriv_reg[32]}}, deriv_reg};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        sh_c  = 2'd0;
        unique case (cmd.mul_sel)
            MS_P:
            begin
                mul_a = gain_p_reg;
                mul_b = {e_reg[15], e_reg};
            end
            MS_I0, MS_I1, MS_I2:
            begin
                mul_a = gain_i_reg;
                sh_c  = 2'(3'(cmd.mul_sel) - 3'(MS_I0));
                mul_b = chunk_of(integ48, sh_c);
            end
            MS_D0, MS_D1, MS_D2:
            begin
                mul_a = gain_d_reg;
                sh_c  = 2'(3'(cmd.mul_sel) - 3'(MS_D0));
                mul_b = chunk_of(deriv48, sh_c);
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    always_comb
    begin
        case (sh_reg)
            2'd0:    addend = {{31{mprod_reg[48]}}, mprod_reg};
            2'd1:    addend = {{15{mprod_reg[48]}}, mprod_reg, 16'd0};
            default: addend = {mprod_reg[47:0], 32'd0};
        endcase
    end

    assign res_s = acc_reg[79:16];
    assign up_s  = {{32{upper_reg[31]}}, upper_reg};
    assign lo_s  = {{32{lower_reg[31]}}, lower_reg};

    assign oldest    = win_reg[ptr_reg];
    assign wsum_next = wsum_reg - {{4{oldest[39]}}, oldest} + {{7{prod_reg[36]}}, prod_reg};
    assign ptr_next  = (ptr_reg == HIST_IDX_W'(HISTORY_DEPTH - 1)) ? '0 : ptr_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            e_reg <= error_sample;
            t_reg <= elapsed_us;
        end
        if (cmd.prep)
        begin
            prod_reg <= prod_c;
            neg_reg  <= diff[16];
            div_reg  <= {diff_mag[15:0], 16'd0};
            rem_reg  <= '0;
            acc_reg  <= '0;
        end
        if (cmd.div_step)
        begin
            div_reg <= {div_reg[30:0], geq};
            rem_reg <= geq ? rem_sub[19:0] : rem_sh[19:0];
        end
        if (cmd.mul_en)
        begin
            mprod_reg <= mul_p;
            sh_reg    <= sh_c;
            if (cmd.mul_sel == MS_P)
            begin
                deriv_reg <= deriv_c;
                integ_reg <= {wsum_reg[43], wsum_reg} + {{8{prod_reg[36]}}, prod_reg};
            end
        end
        if (cmd.acc_en)
        begin
            acc_reg <= acc_reg + addend;
        end
        if (cmd.finish)
        begin
            if (res_s > up_s)
            begin
                drive_reg   <= upper_reg;
                clamped_reg <= 1'b1;
            end
            else if (res_s < lo_s)
            begin
                drive_reg   <= lower_reg;
                clamped_reg <= 1'b1;
            end
            else
            begin
                drive_reg   <= res_s[31:0];
                clamped_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg <= '0;
            gain_i_reg <= '0;
            gain_d_reg <= '0;
            upper_reg  <= 32'h7FFF_FFFF;
            lower_reg  <= 32'h8000_0000;
            last_reg   <= '0;
            ptr_reg    <= '0;
            wsum_reg   <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GAIN_P:    gain_p_reg <= cfg_data;
                    REG_GAIN_I:    gain_i_reg <= cfg_data;
                    REG_GAIN_D:    gain_d_reg <= cfg_data;
                    REG_OUT_UPPER: upper_reg  <= cfg_data;
                    REG_OUT_LOWER: lower_reg  <= cfg_data;
                    default:       gain_p_reg <= gain_p_reg;
                endcase
            end
            if (cmd.finish)
            begin
                last_reg         <= e_reg;
                wsum_reg         <= wsum_next;
                win_reg[ptr_reg] <= {{3{prod_reg[36]}}, prod_reg};
                ptr_reg          <= ptr_next;
            end
        end
    end

    assign drive   = drive_reg;
    assign clamped = clamped_reg;

endmodule

`default_nettype wire

### hdl/pid_windowed_integral.sv
// top level of the pid controller with sliding-window integral
//
//  channel  direction  signals                         accepted when
//  in       input      error_sample, elapsed_us        in_valid & in_ready
//  out      output     drive, clamped                  out_valid & out_ready
//  cfg      input      cfg_index, cfg_data             cfg_we
//
// one item in flight at a time; the divide is skipped when elapsed_us is zero
// the bit-serial divider for the derivative runs 32 steps
// the multiply-accumulate reuses one 32x17 multiplier over 7 steps
// a new item is taken while a result waits in the output register
// a finished item stalls in its last step until the output register frees
// reset clears gains, window, running sum and previous error, and sets the bounds to the full signed range
`default_nettype none

module pid_windowed_integral (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [pwi_pkg::ERR_W-1:0]      error_sample,
    input  wire logic [pwi_pkg::TIME_W-1:0]     elapsed_us,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [31:0]                         drive,
    output logic                                clamped,
    input  wire logic                           cfg_we,
    input  wire logic [pwi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [pwi_pkg::CFG_W-1:0]      cfg_data
);
    import pwi_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    pwi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    pwi_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .error_sample (error_sample),
        .elapsed_us   (elapsed_us),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .drive        (drive),
        .clamped      (clamped)
    );

endmodule

`default_nettype wire

### hdl/pwi_checker.sv
// port-level checks for the pid controller and their binding
`default_nettype none

module pwi_port_props (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [31:0] drive,
    input wire logic        clamped
);

    // a waiting result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(drive) && $stable(clamped))
        else $error("result changed while stalled");

    // an accepted item keeps the block busy through its prep state, its first divide state and the state after that
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("input taken again too soon");

    // a new result appears only as the block goes idle
    a_result_on_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result raised while still busy");

    // an idle block with no item makes no result
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid && out_valid && out_ready |=> !out_valid)
        else $error("result with no item");

endmodule

bind pid_windowed_integral pwi_port_props u_pwi_port_props (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .drive     (drive),
    .clamped   (clamped)
);

`default_nettype wire
